// ===== rtl/sbfd_pkg.sv =====
// Shared types and constants for the SBUS frame decoder.
`default_nettype none

package sbfd_pkg;

    localparam int FRAME_LEN  = 25;
    localparam int DATA_BYTES = 22;
    localparam int CHAN_COUNT = 16;
    localparam int CHAN_W     = 11;
    localparam int ADDR_W     = 3;

    localparam logic [7:0]  FRAME_HEAD    = 8'h0F;
    localparam logic [7:0]  FRAME_TAIL    = 8'h00;
    localparam logic [15:0] TIMEOUT_RESET = 16'd300;

    // Register index, taken from paddr above the byte offset
    localparam logic [ADDR_W-3:0] REG_TIMEOUT = 1'b0;

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } opcode_t;

    // One run of sixteen channels: packed channel bits, channel 0 lowest
    typedef struct packed {
        logic                      good;
        logic [8*DATA_BYTES-1:0]   data;
    } run_t;

endpackage

`default_nettype wire

// ===== rtl/sbfd_run_emitter.sv =====
// Two-slot run buffer that plays out one run of sixteen channel items.
`default_nettype none

module sbfd_run_emitter (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         push_valid,
    input  wire sbfd_pkg::run_t               push_run,
    output logic                              pend_full,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [3:0]                        m_channel_index,
    output logic [sbfd_pkg::CHAN_W-1:0]       m_channel_value,
    output logic                              m_link_up,
    output logic                              m_last_of_run
);
    import sbfd_pkg::*;

    localparam logic [3:0] LAST_IDX = 4'(CHAN_COUNT - 1);

    run_t       pend_reg,       pend_next;
    logic       pend_valid_reg, pend_valid_next;
    run_t       act_reg,        act_next;
    logic       act_valid_reg,  act_valid_next;
    logic [3:0] idx_reg,        idx_next;

    logic out_fire;
    logic run_done;
    logic pop;

    assign out_fire = act_valid_reg && m_ready;
    assign run_done = out_fire && (idx_reg == LAST_IDX);
    assign pop      = pend_valid_reg && (!act_valid_reg || run_done);

    always_comb begin
        act_next       = act_reg;
        act_valid_next = act_valid_reg;
        idx_next       = idx_reg;
        if (pop) begin
            act_next       = pend_reg;
            act_valid_next = 1'b1;
            idx_next       = '0;
        end else if (run_done) begin
            act_valid_next = 1'b0;
            idx_next       = '0;
        end else if (out_fire) begin
            act_next.data = act_reg.data >> CHAN_W;
            idx_next      = idx_reg + 4'd1;
        end

        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        if (push_valid) begin
            pend_next       = push_run;
            pend_valid_next = 1'b1;
        end else if (pop) begin
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            act_valid_reg  <= 1'b0;
            idx_reg        <= '0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            act_valid_reg  <= act_valid_next;
            idx_reg        <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg <= pend_next;
        act_reg  <= act_next;
    end

    assign pend_full       = pend_valid_reg;
    assign m_valid         = act_valid_reg;
    assign m_channel_index = idx_reg;
    assign m_channel_value = act_reg.data[CHAN_W-1:0];
    assign m_link_up       = act_reg.good;
    assign m_last_of_run   = (idx_reg == LAST_IDX);

endmodule

`default_nettype wire

// ===== rtl/sbus_frame_decoder.sv =====
// Top level of the SBUS frame decoder: byte window, link timer, APB register.
//
//   Channel   Direction  Handshake             Payload
//   s_        in         s_valid / s_ready     s_opcode, s_rx_byte
//   m_        out        m_valid / m_ready     m_channel_index, m_channel_value,
//                                              m_link_up, m_last_of_run
//   APB       in/out     psel, penable, pready paddr, pwdata, prdata
//
// One input item is taken per cycle while s_ready is high; the window, fill
// count and link timer update in the accepting cycle. A good frame or a timeout
// queues one run of sixteen channel items, played out at m_ one per cycle while
// m_ready is high. Two runs can be held (one playing, one waiting); s_ready drops
// only while the waiting slot is occupied. Reset is synchronous, active low, and
// leaves the link down with the timer saturated and the window empty.
`default_nettype none

module sbus_frame_decoder (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // input item channel
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [0:0]                    s_opcode,
    input  wire logic [7:0]                    s_rx_byte,
    // result item channel
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [3:0]                         m_channel_index,
    output logic [sbfd_pkg::CHAN_W-1:0]        m_channel_value,
    output logic                               m_link_up,
    output logic                               m_last_of_run,
    // register port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [sbfd_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import sbfd_pkg::*;

    localparam logic [4:0] FILL_FULL = 5'(FRAME_LEN - 1);

    // Window: newest byte at the top, oldest at index 0
    logic [7:0]  win_reg [0:FRAME_LEN-1];
    logic [4:0]  fill_reg,    fill_next;
    logic [15:0] elapsed_reg, elapsed_next;
    logic        link_reg,    link_next;
    logic [15:0] timeout_reg;

    logic        s_fire;
    logic        is_tick;
    logic [15:0] elapsed_inc;
    logic        frame_full;
    logic        good_frame;
    logic        timeout_hit;
    logic        push_valid;
    run_t        push_run;
    logic        pend_full;
    logic [8*DATA_BYTES-1:0] frame_data;
    logic        cfg_wr;

    assign s_fire  = s_valid && s_ready;
    assign s_ready = !pend_full;
    assign is_tick = (s_opcode == OP_TICK);

    // Saturating tick count
    assign elapsed_inc = (elapsed_reg == 16'hFFFF) ? elapsed_reg : elapsed_reg + 16'd1;
    assign timeout_hit = link_reg && (elapsed_inc > timeout_reg);

    // With 24 bytes held the incoming byte completes the window; the byte at
    // index 1 becomes the oldest once the window shifts.
    assign frame_full = (fill_reg == FILL_FULL);
    assign good_frame = frame_full && (win_reg[1] == FRAME_HEAD) && (s_rx_byte == FRAME_TAIL);

    // Channel bytes 1..22 of the completed window sit at indices 2..23 now
    always_comb begin
        for (int k = 0; k < DATA_BYTES; k++) begin
            frame_data[8*k +: 8] = win_reg[k+2];
        end
    end

    // Queue a run on a good frame or on the tick that drops the link
    assign push_valid    = s_fire && (is_tick ? timeout_hit : good_frame);
    assign push_run.good = !is_tick;
    assign push_run.data = is_tick ? '0 : frame_data;

    always_comb begin
        fill_next    = fill_reg;
        elapsed_next = elapsed_reg;
        link_next    = link_reg;
        if (s_fire) begin
            if (is_tick) begin
                elapsed_next = elapsed_inc;
                if (timeout_hit) begin
                    link_next = 1'b0;
                end
            end else if (good_frame) begin
                // empty the window and restart the timer
                fill_next    = '0;
                elapsed_next = '0;
                link_next    = 1'b1;
            end else if (!frame_full) begin
                fill_next = fill_reg + 5'd1;
            end
            // a full window with a bad header or trailer slides: hold the count
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            elapsed_reg <= 16'hFFFF;
            link_reg    <= 1'b0;
        end else begin
            fill_reg    <= fill_next;
            elapsed_reg <= elapsed_next;
            link_reg    <= link_next;
        end
    end

    // Shift every accepted byte in at the top; drop the oldest
    always_ff @(posedge aclk) begin
        if (s_fire && !is_tick) begin
            for (int i = 0; i < FRAME_LEN - 1; i++) begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[FRAME_LEN-1] <= s_rx_byte;
        end
    end

    // Register port: timeout at index 0, other addresses ignored
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
        end else if (cfg_wr && (paddr[ADDR_W-1:2] == REG_TIMEOUT)) begin
            timeout_reg <= pwdata[15:0];
        end
    end

    assign prdata = (paddr[ADDR_W-1:2] == REG_TIMEOUT) ? {16'b0, timeout_reg} : '0;

    sbfd_run_emitter u_emitter (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .push_valid      (push_valid),
        .push_run        (push_run),
        .pend_full       (pend_full),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_channel_index (m_channel_index),
        .m_channel_value (m_channel_value),
        .m_link_up       (m_link_up),
        .m_last_of_run   (m_last_of_run)
    );

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_FULL)
        else $error("fill count beyond window size");

    a_timeout_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_link_up) |-> (m_channel_value == '0))
        else $error("timeout run carries non-zero channel");

    a_link_timer: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(link_reg) |-> (elapsed_reg == 16'd0 && fill_reg == 5'd0))
        else $error("link came up without timer and window restart");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid |=> pend_full)
        else $error("queued run not held");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/sbus_frame_decoder_checker.sv =====
// Scoreboard for the SBUS frame decoder: watches both channels and the register port.
module sbus_frame_decoder_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [0:0]                    s_opcode,
    input  logic [7:0]                    s_rx_byte,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [3:0]                    m_channel_index,
    input  logic [sbfd_pkg::CHAN_W-1:0]   m_channel_value,
    input  logic                          m_link_up,
    input  logic                          m_last_of_run,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [sbfd_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output int                            fail_count,
    output int                            channels_due,
    output int                            frame_runs,
    output int                            loss_runs
);
    timeunit 1ns;
    timeprecision 1ps;
    import sbfd_pkg::*;

    typedef struct packed {
        logic [3:0]        index;
        logic [CHAN_W-1:0] value;
        logic              link_up;
        logic              last;
    } channel_item_t;

    logic [7:0]    window_bytes [FRAME_LEN];
    int            bytes_held;
    logic [15:0]   ticks_since_frame;
    logic          link_alive;
    logic [15:0]   timeout_limit;
    channel_item_t channel_queue [$];

    function automatic logic [CHAN_W-1:0] channel_from_window(int k);
        int         bitpos;
        int         first;
        logic [23:0] span;
        bitpos = CHAN_W * k;
        first  = 1 + bitpos / 8;
        span   = {window_bytes[first + 2], window_bytes[first + 1], window_bytes[first]};
        return CHAN_W'(span >> (bitpos % 8));
    endfunction

    task automatic queue_run(logic good);
        channel_item_t item;
        for (int k = 0; k < CHAN_COUNT; k++) begin
            item.index   = 4'(k);
            item.value   = good ? channel_from_window(k) : '0;
            item.link_up = good;
            item.last    = (k == CHAN_COUNT - 1);
            channel_queue.push_back(item);
        end
        if (good) frame_runs++;
        else loss_runs++;
    endtask

    task automatic absorb_item(opcode_t op, logic [7:0] rx);
        if (op == OP_TICK) begin
            if (ticks_since_frame != 16'hFFFF) ticks_since_frame++;
            if (link_alive && ticks_since_frame > timeout_limit) begin
                link_alive = 1'b0;
                queue_run(1'b0);
            end
            return;
        end
        if (bytes_held >= FRAME_LEN) bytes_held = FRAME_LEN - 1;
        window_bytes[bytes_held] = rx;
        bytes_held++;
        if (bytes_held < FRAME_LEN) return;
        if (window_bytes[0] == FRAME_HEAD && window_bytes[FRAME_LEN - 1] == FRAME_TAIL) begin
            queue_run(1'b1);
            bytes_held        = 0;
            ticks_since_frame = '0;
            link_alive        = 1'b1;
        end else begin
            // slide: drop the oldest byte
            for (int i = 0; i < FRAME_LEN - 1; i++) window_bytes[i] = window_bytes[i + 1];
            bytes_held = FRAME_LEN - 1;
        end
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    initial begin
        fail_count   = 0;
        channels_due = 0;
        frame_runs   = 0;
        loss_runs    = 0;
    end

    always @(posedge aclk) begin
        channel_item_t want;
        if (!aresetn) begin
            bytes_held        = 0;
            ticks_since_frame = 16'hFFFF;
            link_alive        = 1'b0;
            timeout_limit     = TIMEOUT_RESET;
            channel_queue.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr[ADDR_W-1:2] == REG_TIMEOUT)
                timeout_limit = pwdata[15:0];
            if (s_valid && s_ready)
                absorb_item(opcode_t'(s_opcode), s_rx_byte);
            if (m_valid && m_ready) begin
                if (channel_queue.size() == 0) begin
                    $error("unexpected channel item: index %0d value %0d link_up %0d",
                           m_channel_index, m_channel_value, m_link_up);
                    fail_count++;
                end else begin
                    want = channel_queue.pop_front();
                    check_field("channel_index", want.index, m_channel_index);
                    check_field("channel_value", want.value, m_channel_value);
                    check_field("link_up", want.link_up, m_link_up);
                    check_field("last_of_run", want.last, m_last_of_run);
                end
            end
        end
        channels_due = channel_queue.size();
    end

endmodule

// ===== tb/sv/sbus_frame_decoder_tb.sv =====
// Top of the SBUS frame decoder testbench: clock, reset, stimulus and verdict.
module sbus_frame_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sbfd_pkg::*;

    // Cycles to let the block settle after the last expected item
    localparam int SETTLE_CYCLES = 8;
    // Cycles with no item moving on either channel before the run is abandoned
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASE_ITEMS   = 24;

    localparam logic [ADDR_W-1:0] TIMEOUT_ADDR = {REG_TIMEOUT, 2'b00};
    // Next word up: no register lives there, writes must be dropped
    localparam logic [ADDR_W-1:0] UNUSED_ADDR  = {~REG_TIMEOUT, 2'b00};

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [0:0]          s_opcode;
    logic [7:0]          s_rx_byte;
    logic                m_valid;
    logic                m_ready;
    logic [3:0]          m_channel_index;
    logic [CHAN_W-1:0]   m_channel_value;
    logic                m_link_up;
    logic                m_last_of_run;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    int fail_count;
    int channels_due;
    int frame_runs;
    int loss_runs;
    int items_sent;
    int settings_used;
    // When set, neither side idles: back-to-back traffic
    logic calm;

    sbus_frame_decoder dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_channel_index (m_channel_index),
        .m_channel_value (m_channel_value),
        .m_link_up       (m_link_up),
        .m_last_of_run   (m_last_of_run),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    sbus_frame_decoder_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_channel_index (m_channel_index),
        .m_channel_value (m_channel_value),
        .m_link_up       (m_link_up),
        .m_last_of_run   (m_last_of_run),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .fail_count      (fail_count),
        .channels_due    (channels_due),
        .frame_runs      (frame_runs),
        .loss_runs       (loss_runs)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Idle length: mostly short, now and then a long pause
    function automatic int pause_length();
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    function automatic int sender_gap();
        if (calm || $urandom_range(0, 99) < 55) return 0;
        return pause_length();
    endfunction

    // Result side: hold m_ready low for random stretches, unless traffic is calm
    initial begin : result_sink
        int hold;
        m_ready = 1'b0;
        hold    = 0;
        forever begin
            @(negedge aclk);
            if (hold > 0) begin
                m_ready <= 1'b0;
                hold--;
            end else begin
                m_ready <= 1'b1;
                if (!calm && $urandom_range(0, 99) < 25) hold = pause_length();
            end
        end
    end

    // Called at a falling edge; returns at a falling edge once the item is taken.
    // Keep valid high straight into the next item when no gap is drawn.
    task automatic send_item(opcode_t op, logic [7:0] rx);
        int gap;
        s_valid   <= 1'b1;
        s_opcode  <= op;
        s_rx_byte <= rx;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        items_sent++;
        gap = sender_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    // Setup cycle, then access cycle; the register takes the data on the access edge
    task automatic write_reg(logic [ADDR_W-1:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Drain every outstanding channel item, then give the block a few spare cycles
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (channels_due != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_timeout(logic [15:0] ticks);
        wait_idle();
        write_reg(TIMEOUT_ADDR, {16'h0, ticks});
        settings_used++;
    endtask

    // Send one frame. Damage: head replaced, tail replaced, or cut short.
    typedef enum int {
        FRAME_CLEAN,
        FRAME_BAD_HEAD,
        FRAME_BAD_TAIL,
        FRAME_CUT
    } frame_damage_t;

    task automatic send_frame(logic all_ones, frame_damage_t damage);
        logic [7:0] bytes [FRAME_LEN];
        int         count;
        bytes[0] = FRAME_HEAD;
        for (int i = 1; i < FRAME_LEN - 1; i++)
            bytes[i] = all_ones ? 8'hFF : 8'($urandom_range(0, 255));
        bytes[FRAME_LEN - 1] = FRAME_TAIL;
        count = FRAME_LEN;
        case (damage)
            FRAME_BAD_HEAD: begin
                do bytes[0] = 8'($urandom_range(0, 255)); while (bytes[0] == FRAME_HEAD);
            end
            FRAME_BAD_TAIL: begin
                do bytes[FRAME_LEN - 1] = 8'($urandom_range(0, 255));
                while (bytes[FRAME_LEN - 1] == FRAME_TAIL);
            end
            FRAME_CUT: count = $urandom_range(1, FRAME_LEN - 1);
            default: ;
        endcase
        for (int i = 0; i < count; i++) send_item(OP_BYTE, bytes[i]);
    endtask

    // Ticks carry a random byte too: the block must ignore it
    task automatic send_ticks(int count);
        repeat (count) send_item(OP_TICK, 8'($urandom_range(0, 255)));
    endtask

    // One random phase: mostly clean frames, some noise, broken frames and tick bursts
    task automatic run_phase(logic [15:0] ticks, logic quiet_flow);
        int first;
        int pick;
        set_timeout(ticks);
        calm  = quiet_flow;
        first = items_sent;
        while (items_sent - first < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                repeat ($urandom_range(0, 2)) send_item(OP_BYTE, 8'($urandom_range(0, 255)));
                send_frame(1'b0, FRAME_CLEAN);
            end else if (pick < 70) begin
                send_frame(1'b0, frame_damage_t'($urandom_range(FRAME_BAD_HEAD, FRAME_CUT)));
            end else begin
                send_ticks($urandom_range(1, 20));
            end
        end
        calm = 1'b0;
    endtask

    // Abandon the run when nothing moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
        $display("** sbus_frame_decoder: FAILED **");
        $finish;
    end

    initial begin
        s_valid       = 1'b0;
        s_opcode      = OP_BYTE;
        s_rx_byte     = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        aresetn       = 1'b0;
        calm          = 1'b0;
        items_sent    = 0;
        settings_used = 0;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: a write to the empty slot must leave the timeout at its reset value
        write_reg(UNUSED_ADDR, 32'h0);
        // Full-scale frame: every channel at its top value
        send_frame(1'b1, FRAME_CLEAN);
        // One tick is far inside the default timeout: no link-loss run
        send_ticks(1);
        // Zero timeout: the next tick drops the link
        set_timeout(16'd0);
        send_ticks(1);

        // Random phases across the timeout range, the extremes among them
        run_phase(16'd1, 1'b0);
        run_phase(16'hFFFF, 1'b0);
        run_phase(16'd13, 1'b1);
        run_phase(16'hFFFE, 1'b0);
        run_phase(16'd4, 1'b0);
        run_phase(16'd0, 1'b0);
        run_phase(TIMEOUT_RESET, 1'b0);

        wait_idle();
        repeat (SETTLE_CYCLES) @(negedge aclk);

        $display("Run covered %0d input items under %0d timeout settings.",
                 items_sent, settings_used + 1);
        $display("Checked %0d decoded frames and %0d link-loss runs channel by channel.",
                 frame_runs, loss_runs);
        if (fail_count == 0) begin
            $display("** sbus_frame_decoder: PASSED **");
        end else begin
            $display("** sbus_frame_decoder: FAILED **");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/sbfd_pkg.sv
rtl/sbfd_run_emitter.sv
rtl/sbus_frame_decoder.sv
tb/sv/sbus_frame_decoder_checker.sv
tb/sv/sbus_frame_decoder_tb.sv
